### hdl/cbse_pkg.sv
// Shared constants, request codes and the arctangent table of the cubic B-spline evaluator.
// No dependencies; the evaluator top level refers to it by scoped names.
package cbse_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int SUPPORT          = 4;
    localparam int ONE_Q16          = 65536;
    localparam int PI_Q13           = 25736;
    localparam int HALF_PI_Q13      = 12868;
    localparam int HALF_PI_Q20      = 1647099;
    localparam int CORDIC_STEPS     = 20;
    // floor(2^32 / 3), the reciprocal used to divide by three
    localparam logic [31:0] DIV3_RECIP = 32'h5555_5555;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_COMMIT  = 2'd1,
        ACT_POINT   = 2'd2,
        ACT_HEADING = 2'd3
    } action_t;

    // atan(2^-i) in Q20 radians
    function automatic logic signed [22:0] atan_q20(input logic [4:0] i);
        logic signed [22:0] r;
        begin
            unique case (i)
                5'd0:  r = 23'sd823550;
                5'd1:  r = 23'sd486170;
                5'd2:  r = 23'sd256879;
                5'd3:  r = 23'sd130396;
                5'd4:  r = 23'sd65451;
                5'd5:  r = 23'sd32757;
                5'd6:  r = 23'sd16383;
                5'd7:  r = 23'sd8192;
                5'd8:  r = 23'sd4096;
                5'd9:  r = 23'sd2048;
                5'd10: r = 23'sd1024;
                5'd11: r = 23'sd512;
                5'd12: r = 23'sd256;
                5'd13: r = 23'sd128;
                5'd14: r = 23'sd64;
                5'd15: r = 23'sd32;
                5'd16: r = 23'sd16;
                5'd17: r = 23'sd8;
                5'd18: r = 23'sd4;
                5'd19: r = 23'sd2;
                default: r = 23'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

### hdl/cubic_bspline_evaluator_unit.sv
// Uniform cubic B-spline evaluator: coefficient memories, weight datapath, blend and CORDIC atan2.
// Depends on cbse_pkg.
//
// Write and commit requests are handled at acceptance. A point request passes five weight
// stages (squares, cubes, basis and a divide by three as reciprocal estimate and correction),
// then reads each coefficient memory four times at one read per cycle through a multiply and
// accumulate pipe, then a rounding stage and the hand-off to the output register. A heading
// request skips the divide stages and then runs a normalizing shifter one bit per cycle and a
// 20-step CORDIC; when the derivative is zero or lies on an axis, both are skipped. An
// evaluation before commit goes straight to the hand-off. One request is in work at a time;
// the next is taken once the result sits in the output register, which the downstream side may
// hold while the next request is accepted.
module cubic_bspline_evaluator_unit #(
    parameter int MAX_SEGMENTS = cbse_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,        // number of segments in use
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] coef_index, [7] coef_axis, [39:8] coef_value, [57:40] param_t, [63:58] zero
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,    // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [79:64] heading
    output logic [79:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser     // [0] ready_flag
);

    localparam int DEPTH = MAX_SEGMENTS + 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_SEGMENTS + 1);
    localparam int PW    = 17 + SW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_CU, ST_BW, ST_DV, ST_DC, ST_MAC, ST_FIN,
        ST_NORM, ST_CORD, ST_ANG, ST_QD, ST_RES
    } state_t;

    state_t state_reg;

    // coefficient memories
    logic [31:0] mem_x [DEPTH];
    logic [31:0] mem_y [DEPTH];
    logic [31:0] rd_x_reg, rd_y_reg;

    logic [6:0]  seg_cnt_reg;
    logic        ready_reg;
    cbse_pkg::action_t act_reg;
    logic [AW-1:0] seg_reg;
    logic [16:0] u_reg;
    logic [32:0] u2_reg, v2_reg;
    logic [48:0] u3_reg, v3_reg;
    logic [31:0] wq_reg [cbse_pkg::SUPPORT];
    logic [31:0] est_reg [cbse_pkg::SUPPORT];

    logic [2:0]  iss_cnt_reg;
    logic        rdv_reg, prv_reg;
    logic [1:0]  rdk_reg;
    logic [1:0]  acc_cnt_reg;
    logic signed [63:0] prod_x_reg, prod_y_reg;
    logic signed [65:0] acc_x_reg, acc_y_reg;

    logic [65:0] ax_reg, ay_reg;
    logic        xneg_reg, yneg_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [22:0] z_reg;
    logic [4:0]  it_reg;
    logic [13:0] ang_reg;

    logic [31:0] res_px_reg, res_py_reg;
    logic [15:0] res_hd_reg;
    logic        res_rdy_reg;

    logic        m_valid_reg;
    logic [79:0] m_data_reg;
    logic        m_user_reg;

    // request fields
    cbse_pkg::action_t in_act;
    logic [6:0]  in_idx;
    logic        in_axis;
    logic [31:0] in_val;
    logic signed [17:0] in_t;
    logic        in_acc;

    assign in_act  = cbse_pkg::action_t'(s_axis_tuser);
    assign in_idx  = s_axis_tdata[6:0];
    assign in_axis = s_axis_tdata[7];
    assign in_val  = s_axis_tdata[39:8];
    assign in_t    = s_axis_tdata[57:40];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // segment lookup at acceptance
    logic [31:0]    s32;
    logic [SW-1:0]  s_eff;
    logic [16:0]    t_c;
    logic [PW-1:0]  scaled;
    logic [SW:0]    seg_raw, seg_c;
    logic [16:0]    u_c;

    always_comb
    begin
        if (seg_cnt_reg == 7'd0)
            s32 = 32'd1;
        else if (32'(seg_cnt_reg) > 32'(MAX_SEGMENTS))
            s32 = 32'(MAX_SEGMENTS);
        else
            s32 = 32'(seg_cnt_reg);
        s_eff = SW'(s32);
        if (in_t[17])
            t_c = 17'd0;
        else if (in_t > 18'sd65536)
            t_c = 17'(cbse_pkg::ONE_Q16);
        else
            t_c = in_t[16:0];
        scaled  = PW'(t_c) * PW'(s_eff);
        seg_raw = scaled[PW-1:16];
        if (seg_raw >= (SW+1)'(s_eff))
            seg_c = (SW+1)'(s_eff) - (SW+1)'(1);
        else
            seg_c = seg_raw;
        u_c = 17'(scaled - (PW'(seg_c) << 16));
    end

    // memory control
    logic          wr_ok, mem_rd_en;
    logic [AW-1:0] mem_addr, wr_addr;

    assign wr_ok     = in_acc && (in_act == cbse_pkg::ACT_WRITE) && (32'(in_idx) < 32'(DEPTH));
    assign wr_addr   = AW'(in_idx);
    assign mem_rd_en = (state_reg == ST_MAC) && (iss_cnt_reg < 3'd4);
    assign mem_addr  = seg_reg + AW'(iss_cnt_reg);

    // write one coefficient, read one pair per cycle
    always_ff @(posedge clk)
    begin
        if (wr_ok && !in_axis)
            mem_x[wr_addr] <= in_val;
        if (wr_ok && in_axis)
            mem_y[wr_addr] <= in_val;
        if (mem_rd_en)
        begin
            rd_x_reg <= mem_x[mem_addr];
            rd_y_reg <= mem_y[mem_addr];
        end
    end

    // basis weights from the cubes and squares
    logic [16:0]        v_w;
    logic signed [55:0] b6 [cbse_pkg::SUPPORT];
    logic signed [39:0] d2 [cbse_pkg::SUPPORT];
    logic [31:0]        wf [cbse_pkg::SUPPORT];
    logic signed [55:0] u3s, u2s16, us32;
    logic signed [39:0] u2s, uq;

    always_comb
    begin
        v_w   = 17'(cbse_pkg::ONE_Q16) - u_reg;
        u3s   = 56'(u3_reg);
        u2s16 = 56'(u2_reg) <<< 16;
        us32  = 56'(u_reg) <<< 32;
        b6[0] = 56'(v3_reg);
        b6[1] = 56'sd3 * u3s - 56'sd6 * u2s16 + (56'sd4 <<< 48);
        b6[2] = -(56'sd3 * u3s) + 56'sd3 * u2s16 + 56'sd3 * us32 + (56'sd1 <<< 48);
        b6[3] = u3s;
        u2s   = 40'(u2_reg);
        uq    = 40'(u_reg) <<< 16;
        d2[0] = -40'(v2_reg);
        d2[1] = 40'sd3 * u2s - 40'sd4 * uq;
        d2[2] = -(40'sd3 * u2s) + 40'sd2 * uq + (40'sd1 <<< 32);
        d2[3] = u2s;
        for (int k = 0; k < cbse_pkg::SUPPORT; k++)
        begin
            if (act_reg == cbse_pkg::ACT_POINT)
                wf[k] = 32'((b6[k] + (56'sd3 <<< 18)) >>> 19);
            else
                wf[k] = 32'((d2[k] + 40'sd4) >>> 3);
        end
    end

    // blend, rounding and saturation
    logic signed [65:0] rx, ry;
    logic [31:0]        sat_x, sat_y;
    logic [65:0]        ax_c, ay_c, or_c;
    logic signed [32:0] sxc, syc;
    logic signed [22:0] zc;
    logic [15:0]        hd_q;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        begin
            if (v > 66'sd2147483647)
                r = 32'h7FFF_FFFF;
            else if (v < -66'sd2147483648)
                r = 32'h8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    always_comb
    begin
        rx    = (acc_x_reg + (66'sd1 <<< 29)) >>> 30;
        ry    = (acc_y_reg + (66'sd1 <<< 29)) >>> 30;
        sat_x = sat32(rx);
        sat_y = sat32(ry);
        ax_c  = acc_x_reg[65] ? 66'(-acc_x_reg) : 66'(acc_x_reg);
        ay_c  = acc_y_reg[65] ? 66'(-acc_y_reg) : 66'(acc_y_reg);
        or_c  = ax_reg | ay_reg;
        sxc   = cx_reg >>> it_reg;
        syc   = cy_reg[32] ? -((-cy_reg) >>> it_reg) : (cy_reg >>> it_reg);
        if (z_reg < 23'sd0)
            zc = 23'sd0;
        else if (z_reg > 23'(cbse_pkg::HALF_PI_Q20))
            zc = 23'(cbse_pkg::HALF_PI_Q20);
        else
            zc = z_reg;
        hd_q = 16'(ang_reg);
        if (xneg_reg)
            hd_q = 16'(cbse_pkg::PI_Q13) - hd_q;
        if (yneg_reg)
            hd_q = -hd_q;
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seg_cnt_reg <= 7'd1;
            ready_reg   <= 1'b0;
            act_reg     <= cbse_pkg::ACT_WRITE;
            seg_reg     <= '0;
            u_reg       <= '0;
            u2_reg      <= '0;
            v2_reg      <= '0;
            u3_reg      <= '0;
            v3_reg      <= '0;
            for (int k = 0; k < cbse_pkg::SUPPORT; k++)
            begin
                wq_reg[k]  <= '0;
                est_reg[k] <= '0;
            end
            iss_cnt_reg <= '0;
            rdv_reg     <= 1'b0;
            prv_reg     <= 1'b0;
            rdk_reg     <= '0;
            acc_cnt_reg <= '0;
            prod_x_reg  <= '0;
            prod_y_reg  <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            ax_reg      <= '0;
            ay_reg      <= '0;
            xneg_reg    <= 1'b0;
            yneg_reg    <= 1'b0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            z_reg       <= '0;
            it_reg      <= '0;
            ang_reg     <= '0;
            res_px_reg  <= '0;
            res_py_reg  <= '0;
            res_hd_reg  <= '0;
            res_rdy_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= 1'b0;
        end
        else
        begin
            // drop a delivered result unless a new one replaces it
            if (m_valid_reg && m_axis_tready && (state_reg != ST_RES))
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        act_reg     <= in_act;
                        seg_reg     <= AW'(seg_c);
                        u_reg       <= u_c;
                        res_px_reg  <= '0;
                        res_py_reg  <= '0;
                        res_hd_reg  <= '0;
                        res_rdy_reg <= ready_reg;
                        unique case (in_act)
                            cbse_pkg::ACT_WRITE:   state_reg <= ST_IDLE;
                            cbse_pkg::ACT_COMMIT:
                            begin
                                if (!cfg_we)
                                    ready_reg <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            cbse_pkg::ACT_POINT,
                            cbse_pkg::ACT_HEADING: state_reg <= ready_reg ? ST_SQ : ST_RES;
                            default:               state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SQ:
                begin
                    u2_reg    <= 33'(u_reg) * 33'(u_reg);
                    v2_reg    <= 33'(v_w) * 33'(v_w);
                    state_reg <= ST_CU;
                end
                ST_CU:
                begin
                    u3_reg    <= 49'(50'(u2_reg) * 50'(u_reg));
                    v3_reg    <= 49'(50'(v2_reg) * 50'(v_w));
                    state_reg <= ST_BW;
                end
                ST_BW:
                begin
                    for (int k = 0; k < cbse_pkg::SUPPORT; k++)
                        wq_reg[k] <= wf[k];
                    iss_cnt_reg <= '0;
                    acc_cnt_reg <= '0;
                    rdv_reg     <= 1'b0;
                    prv_reg     <= 1'b0;
                    acc_x_reg   <= '0;
                    acc_y_reg   <= '0;
                    state_reg   <= (act_reg == cbse_pkg::ACT_POINT) ? ST_DV : ST_MAC;
                end
                ST_DV:
                begin
                    // estimate q/3 through the reciprocal
                    for (int k = 0; k < cbse_pkg::SUPPORT; k++)
                        est_reg[k] <= 32'((64'(wq_reg[k]) * 64'(cbse_pkg::DIV3_RECIP)) >> 32);
                    state_reg <= ST_DC;
                end
                ST_DC:
                begin
                    for (int k = 0; k < cbse_pkg::SUPPORT; k++)
                    begin
                        if ((34'(wq_reg[k]) - 34'(est_reg[k]) * 34'd3) >= 34'd3)
                            wq_reg[k] <= est_reg[k] + 32'd1;
                        else
                            wq_reg[k] <= est_reg[k];
                    end
                    state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    // issue reads, multiply, then accumulate
                    if (iss_cnt_reg < 3'd4)
                    begin
                        iss_cnt_reg <= iss_cnt_reg + 3'd1;
                        rdk_reg     <= iss_cnt_reg[1:0];
                        rdv_reg     <= 1'b1;
                    end
                    else
                        rdv_reg <= 1'b0;
                    prv_reg <= rdv_reg;
                    if (rdv_reg)
                    begin
                        prod_x_reg <= $signed(rd_x_reg) * $signed(wq_reg[rdk_reg]);
                        prod_y_reg <= $signed(rd_y_reg) * $signed(wq_reg[rdk_reg]);
                    end
                    if (prv_reg)
                    begin
                        acc_x_reg   <= acc_x_reg + 66'(prod_x_reg);
                        acc_y_reg   <= acc_y_reg + 66'(prod_y_reg);
                        acc_cnt_reg <= acc_cnt_reg + 2'd1;
                        if (acc_cnt_reg == 2'd3)
                            state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    xneg_reg <= acc_x_reg[65];
                    yneg_reg <= acc_y_reg[65];
                    ax_reg   <= ax_c;
                    ay_reg   <= ay_c;
                    if (act_reg == cbse_pkg::ACT_POINT)
                    begin
                        res_px_reg <= sat_x;
                        res_py_reg <= sat_y;
                        state_reg  <= ST_RES;
                    end
                    else if (ax_c == '0 && ay_c == '0)
                        state_reg <= ST_RES;
                    else if (ay_c == '0)
                    begin
                        ang_reg   <= '0;
                        state_reg <= ST_QD;
                    end
                    else if (ax_c == '0)
                    begin
                        ang_reg   <= 14'(cbse_pkg::HALF_PI_Q13);
                        state_reg <= ST_QD;
                    end
                    else
                        state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    // bring the larger magnitude into [2^29, 2^30)
                    if (|or_c[65:30])
                    begin
                        ax_reg <= ax_reg >> 1;
                        ay_reg <= ay_reg >> 1;
                    end
                    else if (!or_c[29])
                    begin
                        ax_reg <= ax_reg << 1;
                        ay_reg <= ay_reg << 1;
                    end
                    else
                    begin
                        cx_reg    <= 33'(ax_reg[29:0]);
                        cy_reg    <= 33'(ay_reg[29:0]);
                        z_reg     <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_CORD;
                    end
                end
                ST_CORD:
                begin
                    if (cy_reg > 33'sd0)
                    begin
                        cx_reg <= cx_reg + syc;
                        cy_reg <= cy_reg - sxc;
                        z_reg  <= z_reg + cbse_pkg::atan_q20(it_reg);
                    end
                    else
                    begin
                        cx_reg <= cx_reg - syc;
                        cy_reg <= cy_reg + sxc;
                        z_reg  <= z_reg - cbse_pkg::atan_q20(it_reg);
                    end
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'(cbse_pkg::CORDIC_STEPS - 1))
                        state_reg <= ST_ANG;
                end
                ST_ANG:
                begin
                    ang_reg   <= 14'((zc + 23'sd64) >>> 7);
                    state_reg <= ST_QD;
                end
                ST_QD:
                begin
                    res_hd_reg <= hd_q;
                    state_reg  <= ST_RES;
                end
                ST_RES:
                begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {res_hd_reg, res_py_reg, res_px_reg};
                        m_user_reg  <= res_rdy_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // a new segment count invalidates the tables
            if (cfg_we)
            begin
                seg_cnt_reg <= cfg_data;
                ready_reg   <= 1'b0;
            end
        end
    end

endmodule

### sim/cubic_bspline_evaluator_unit_tb.sv
// Self-checking testbench for the cubic B-spline evaluator: predicts each point and heading result.
// Depends on cbse_pkg and cubic_bspline_evaluator_unit; needs no files or arguments.
`timescale 1ns / 100ps

module cubic_bspline_evaluator_unit_tb;

    localparam int TABLE_DEPTH = cbse_pkg::MAX_SEGMENTS_DEF + 3;

    typedef struct {
        int          px;
        int          py;
        logic [15:0] hd;
        logic        rdy;
    } spline_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Shadow state of the block
    int  x_tab [TABLE_DEPTH];
    int  y_tab [TABLE_DEPTH];
    bit  tab_ready;
    int  seg_cnt;

    spline_result_t pending_results[$];
    int  err_cnt = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    longint atan_tab [cbse_pkg::CORDIC_STEPS] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    cubic_bspline_evaluator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint floor_div(longint v, longint d);
        longint q;
        begin
            q = v / d;
            if (v % d != 0 && v < 0)
                q--;
            return q;
        end
    endfunction

    function automatic int sat32(longint v);
        begin
            if (v > 64'sd2147483647)
                return 32'h7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return int'(v);
        end
    endfunction

    // Tangent angle in Q3.13 by a 20-step CORDIC on normalized magnitudes
    function automatic logic [15:0] tangent_angle(longint y, longint x);
        longint ax, ay, cx, cy, z, sx, sy, a, d;
        begin
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            if (ax == 0 && ay == 0)
                return 16'd0;
            if (ay == 0)
                a = 0;
            else if (ax == 0)
                a = cbse_pkg::HALF_PI_Q13;
            else
            begin
                while ((ax | ay) >= (64'sd1 <<< 30))
                begin
                    ax = ax >>> 1;
                    ay = ay >>> 1;
                end
                while ((ax | ay) < (64'sd1 <<< 29))
                begin
                    ax = ax <<< 1;
                    ay = ay <<< 1;
                end
                cx = ax;
                cy = ay;
                z = 0;
                for (int i = 0; i < cbse_pkg::CORDIC_STEPS; i++)
                begin
                    d = 64'sd1 <<< i;
                    sx = cx / d;
                    sy = cy / d;
                    if (cy > 0)
                    begin
                        cx += sy;
                        cy -= sx;
                        z += atan_tab[i];
                    end
                    else
                    begin
                        cx -= sy;
                        cy += sx;
                        z -= atan_tab[i];
                    end
                end
                if (z < 0)
                    z = 0;
                if (z > cbse_pkg::HALF_PI_Q20)
                    z = cbse_pkg::HALF_PI_Q20;
                a = (z + 64) / 128;
            end
            if (x < 0)
                a = cbse_pkg::PI_Q13 - a;
            if (y < 0)
                a = -a;
            return a[15:0];
        end
    endfunction

    // Update the shadow tables and queue the result that this request causes
    task automatic model_request(cbse_pkg::action_t act, int idx, bit axis, int val,
                                 logic [17:0] pt);
        spline_result_t r;
        longint t, s, scaled, seg, u, v, u2, u3, uq, sumx, sumy;
        longint w [cbse_pkg::SUPPORT];
        longint b [cbse_pkg::SUPPORT];
        longint dv;
        begin
            if (act == cbse_pkg::ACT_WRITE)
            begin
                if (idx < TABLE_DEPTH)
                begin
                    if (axis)
                        y_tab[idx] = val;
                    else
                        x_tab[idx] = val;
                end
                return;
            end
            if (act == cbse_pkg::ACT_COMMIT)
            begin
                tab_ready = 1'b1;
                return;
            end
            r = '{0, 0, 16'd0, 1'b0};
            if (tab_ready)
            begin
                r.rdy = 1'b1;
                s = seg_cnt;
                if (s == 0)
                    s = 1;
                if (s > cbse_pkg::MAX_SEGMENTS_DEF)
                    s = cbse_pkg::MAX_SEGMENTS_DEF;
                t = longint'($signed(pt));
                if (t < 0)
                    t = 0;
                if (t > cbse_pkg::ONE_Q16)
                    t = cbse_pkg::ONE_Q16;
                scaled = t * s;
                seg = scaled >>> 16;
                if (seg >= s)
                    seg = s - 1;
                u = scaled - (seg <<< 16);
                v = cbse_pkg::ONE_Q16 - u;
                u2 = u * u;
                u3 = u2 * u;
                if (act == cbse_pkg::ACT_POINT)
                begin
                    dv = 6 * (64'sd1 <<< 18);
                    b[0] = v * v * v;
                    b[1] = 3 * u3 - 6 * (u2 <<< 16) + (64'sd4 <<< 48);
                    b[2] = -3 * u3 + 3 * (u2 <<< 16) + 3 * (u <<< 32) + (64'sd1 <<< 48);
                    b[3] = u3;
                    for (int i = 0; i < cbse_pkg::SUPPORT; i++)
                        w[i] = (b[i] + dv / 2) / dv;
                end
                else
                begin
                    uq = u <<< 16;
                    b[0] = -(v * v);
                    b[1] = 3 * u2 - 4 * uq;
                    b[2] = -3 * u2 + 2 * uq + (64'sd1 <<< 32);
                    b[3] = u2;
                    for (int i = 0; i < cbse_pkg::SUPPORT; i++)
                        w[i] = floor_div(b[i] + 4, 8);
                end
                sumx = 0;
                sumy = 0;
                for (int i = 0; i < cbse_pkg::SUPPORT; i++)
                begin
                    sumx += longint'(x_tab[seg + i]) * w[i];
                    sumy += longint'(y_tab[seg + i]) * w[i];
                end
                if (act == cbse_pkg::ACT_POINT)
                begin
                    r.px = sat32(floor_div(sumx + (64'sd1 <<< 29), 64'sd1 <<< 30));
                    r.py = sat32(floor_div(sumy + (64'sd1 <<< 29), 64'sd1 <<< 30));
                end
                else
                    r.hd = tangent_angle(sumy, sumx);
            end
            pending_results.push_back(r);
        end
    endtask

    // Drive one request and hold it until the block takes it
    task automatic send_request(cbse_pkg::action_t act, int idx, bit axis, int val,
                                logic [17:0] pt);
        begin
            if ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < send_idle_pct)
                    @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= act;
            s_axis_tdata  <= {6'b0, pt, val, axis, idx[6:0]};
            do
                @(posedge clk);
            while (!s_axis_tready);
            model_request(act, idx, axis, val, pt);
        end
    endtask

    // Drop valid, drain all results and let any write or commit finish
    task automatic wait_drained();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (pending_results.size() > 0)
                @(posedge clk);
            repeat (100) @(posedge clk);
        end
    endtask

    task automatic write_segments(logic [6:0] value);
        begin
            wait_drained();
            cfg_we   <= 1'b1;
            cfg_data <= value;
            @(posedge clk);
            cfg_we   <= 1'b0;
            seg_cnt   = value;
            tab_ready = 1'b0;
        end
    endtask

    function automatic int rand_coef();
        begin
            case ($urandom_range(3))
                0:       return int'($urandom);
                1:       return $urandom_range(2097152) - 1048576;
                2:       return $urandom_range(200) - 100;
                default: return $urandom_range(33554432) - 16777216;
            endcase
        end
    endfunction

    function automatic logic [17:0] rand_param();
        begin
            case ($urandom_range(9))
                0, 1:    return 18'($urandom);
                2:       return 18'($urandom_range(3));
                3:       return 18'(cbse_pkg::ONE_Q16 - $urandom_range(3));
                default: return 18'($urandom_range(cbse_pkg::ONE_Q16));
            endcase
        end
    endfunction

    // Evaluations before any commit come back as zeros
    task automatic test_not_ready();
        begin
            send_request(cbse_pkg::ACT_POINT, 0, 1'b0, 0, 18'd32768);
            send_request(cbse_pkg::ACT_HEADING, 0, 1'b0, 0, 18'd0);
        end
    endtask

    // Fill every slot of both tables, then try writes past the end
    task automatic test_load_tables();
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                send_request(cbse_pkg::ACT_WRITE, i, 1'b0, rand_coef(), 18'($urandom));
                send_request(cbse_pkg::ACT_WRITE, i, 1'b1, rand_coef(), 18'($urandom));
            end
            send_request(cbse_pkg::ACT_WRITE, TABLE_DEPTH, 1'b0, 32'h7fff_ffff, 18'd0);
            send_request(cbse_pkg::ACT_WRITE, 127, 1'b1, 32'h8000_0000, 18'h3ffff);
        end
    endtask

    // Edge cases: parameter extremes, zero and backward tangents, saturation
    task automatic test_directed();
        begin
            write_segments(7'd1);
            for (int i = 0; i < cbse_pkg::SUPPORT; i++)
            begin
                send_request(cbse_pkg::ACT_WRITE, i, 1'b0, 0, 18'd0);
                send_request(cbse_pkg::ACT_WRITE, i, 1'b1, 0, 18'd0);
            end
            send_request(cbse_pkg::ACT_COMMIT, 0, 1'b0, 0, 18'd0);
            send_request(cbse_pkg::ACT_HEADING, 0, 1'b0, 0, 18'd0);
            send_request(cbse_pkg::ACT_WRITE, 0, 1'b0, 100, 18'd0);
            send_request(cbse_pkg::ACT_HEADING, 0, 1'b0, 0, 18'd0);
            send_request(cbse_pkg::ACT_WRITE, 1, 1'b0, 32'h7fff_ffff, 18'd0);
            send_request(cbse_pkg::ACT_WRITE, 2, 1'b1, 32'h8000_0000, 18'd0);
            send_request(cbse_pkg::ACT_POINT, 0, 1'b0, 0, 18'd32768);
            send_request(cbse_pkg::ACT_POINT, 0, 1'b0, 0, 18'h20000);
            send_request(cbse_pkg::ACT_POINT, 0, 1'b0, 0, 18'h1ffff);
            send_request(cbse_pkg::ACT_HEADING, 0, 1'b0, 0, 18'd65536);
            send_request(cbse_pkg::ACT_HEADING, 0, 1'b0, 0, 18'd65535);
            write_segments(7'd64);
            send_request(cbse_pkg::ACT_COMMIT, 0, 1'b0, 0, 18'd0);
            send_request(cbse_pkg::ACT_POINT, 0, 1'b0, 0, 18'd65536);
            send_request(cbse_pkg::ACT_HEADING, 0, 1'b0, 0, 18'd1);
            write_segments(7'd0);
            send_request(cbse_pkg::ACT_COMMIT, 0, 1'b0, 0, 18'd0);
            send_request(cbse_pkg::ACT_POINT, 0, 1'b0, 0, 18'd40000);
            write_segments(7'd127);
            send_request(cbse_pkg::ACT_COMMIT, 0, 1'b0, 0, 18'd0);
            send_request(cbse_pkg::ACT_HEADING, 0, 1'b0, 0, 18'd65536);
        end
    endtask

    // Mixed random traffic under one idling pattern
    task automatic test_random_phase(int idle_pct, int stall_pct, logic [6:0] segs, int count);
        int pick;
        begin
            write_segments(segs);
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            send_request(cbse_pkg::ACT_COMMIT, 0, 1'b0, 0, rand_param());
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    send_request(cbse_pkg::ACT_WRITE, ($urandom_range(9) == 0)
                                 ? $urandom_range(127) : $urandom_range(TABLE_DEPTH - 1),
                                 1'($urandom), rand_coef(), 18'($urandom));
                else if (pick < 35)
                    send_request(cbse_pkg::ACT_COMMIT, $urandom_range(127), 1'($urandom),
                                 int'($urandom), 18'($urandom));
                else if (pick < 68)
                    send_request(cbse_pkg::ACT_POINT, $urandom_range(127), 1'($urandom),
                                 int'($urandom), rand_param());
                else
                    send_request(cbse_pkg::ACT_HEADING, $urandom_range(127), 1'($urandom),
                                 int'($urandom), rand_param());
            end
        end
    endtask

    // Randomize the downstream ready for the current phase
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each delivered result with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end
            else
            begin
                automatic spline_result_t e = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== e.px)
                begin
                    $error("point_x expected %0d actual %0d", e.px, $signed(m_axis_tdata[31:0]));
                    err_cnt++;
                end
                if (m_axis_tdata[63:32] !== e.py)
                begin
                    $error("point_y expected %0d actual %0d", e.py, $signed(m_axis_tdata[63:32]));
                    err_cnt++;
                end
                if (m_axis_tdata[79:64] !== e.hd)
                begin
                    $error("heading expected %0d actual %0d", $signed(e.hd),
                           $signed(m_axis_tdata[79:64]));
                    err_cnt++;
                end
                if (m_axis_tuser[0] !== e.rdy)
                begin
                    $error("ready_flag expected %0d actual %0d", e.rdy, m_axis_tuser[0]);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        tab_ready = 1'b0;
        seg_cnt   = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_not_ready();
        test_load_tables();
        test_directed();
        test_random_phase(0, 0, 7'd1, 85);
        test_random_phase(70, 0, 7'd64, 85);
        test_random_phase(0, 70, 7'($urandom_range(2, 63)), 85);
        test_random_phase(18, 18, 7'($urandom_range(1, 64)), 85);
        test_random_phase(0, 0, 7'($urandom_range(127)), 40);
        wait_drained();
        if (err_cnt == 0)
            $display("** cubic_bspline_evaluator_unit: PASSED **");
        else
            $display("** cubic_bspline_evaluator_unit: FAILED **");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        #2000000;
        $display("** cubic_bspline_evaluator_unit: FAILED **");
        $finish;
    end

endmodule

### cubic_bspline_evaluator_unit.f
hdl/cbse_pkg.sv
hdl/cubic_bspline_evaluator_unit.sv
sim/cubic_bspline_evaluator_unit_tb.sv
